@@ hdl/stack_bytecode_executor_core_defines.svh @@
// Assertion macros used by the checker file.
`ifndef STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_CORE_DEFINES_SVH
// Property with a clock edge and a reset guard.
`define SBE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked also during reset.
`define SBE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/sbe_pkg.sv @@
// Package with opcodes, status codes and sizes of the bytecode executor.
`timescale 1ns / 1ps
package sbe_pkg;
  localparam int unsigned StackDepthDef = 16;
  localparam int unsigned LocalCountDef = 16;
  localparam int unsigned InTdataW  = 24;
  localparam int unsigned OutTdataW = 88;

  localparam logic [2:0] StOk     = 3'd0;
  localparam logic [2:0] StDivZ   = 3'd1;
  localparam logic [2:0] StStack  = 3'd2;
  localparam logic [2:0] StLocal  = 3'd3;
  localparam logic [2:0] StUnsup  = 3'd4;

  localparam logic [1:0] FinNone  = 2'd0;
  localparam logic [1:0] FinVoid  = 2'd1;
  localparam logic [1:0] FinValue = 2'd2;

  localparam logic [7:0] OpNop = 8'h00, OpBipush = 8'h10, OpSipush = 8'h11;
  localparam logic [7:0] OpIload = 8'h15, OpAload = 8'h19;
  localparam logic [7:0] OpIstore = 8'h36, OpAstore = 8'h3a, OpDup = 8'h59;
  localparam logic [7:0] OpIadd = 8'h60, OpIsub = 8'h64, OpImul = 8'h68;
  localparam logic [7:0] OpIdiv = 8'h6c, OpIrem = 8'h70, OpIneg = 8'h74;
  localparam logic [7:0] OpIshl = 8'h78, OpIshr = 8'h7a, OpIushr = 8'h7c;
  localparam logic [7:0] OpIand = 8'h7e, OpIor = 8'h80, OpIxor = 8'h82;
  localparam logic [7:0] OpIinc = 8'h84, OpGoto = 8'ha7;
  localparam logic [7:0] OpIfeq = 8'h99, OpIfne = 8'h9a, OpIflt = 8'h9b;
  localparam logic [7:0] OpIfge = 8'h9c, OpIfgt = 8'h9d, OpIfle = 8'h9e;
  localparam logic [7:0] OpCmpeq = 8'h9f, OpCmpne = 8'ha0, OpCmplt = 8'ha1;
  localparam logic [7:0] OpCmpge = 8'ha2, OpCmpgt = 8'ha3, OpCmple = 8'ha4;
  localparam logic [7:0] OpIret = 8'hac, OpAret = 8'hb0, OpRet = 8'hb1;
  localparam logic [7:0] OpGetstatic = 8'hb2, OpInvokevirt = 8'hb6;
  localparam logic [7:0] OpIconstM1 = 8'h02, OpIconst5 = 8'h08;
  localparam logic [7:0] OpIload0 = 8'h1a, OpAload0 = 8'h2a;
  localparam logic [7:0] OpIstore0 = 8'h3b, OpAstore0 = 8'h4b;
  localparam logic [7:0] OpIload3 = 8'h1d, OpAload3 = 8'h2d;
  localparam logic [7:0] OpIstore3 = 8'h3e, OpAstore3 = 8'h4e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_DIV   = 6'b001000,
    S_CLEAR = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;
endpackage

@@ hdl/sbe_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module sbe_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/stack_bytecode_executor_core.sv @@
// Top level of the stack bytecode executor: decode, stack and locals memories.
`timescale 1ns / 1ps
// Usage:
//   s_axis carries one instruction per beat: tdata = {second_byte, first_byte,
//   action} from bit 0 up. m_axis returns one result beat per instruction:
//   tdata = pc_step, print_valid, print_value, finish, return_value, status.
//   Flow: an instruction goes from accept to the result register in steps
//   (read memories, execute, write back); idiv/irem add a pass through a
//   restoring divider that does one quotient bit a cycle. One instruction is
//   in flight at a time; the next beat is accepted once the result beat sits
//   in the output register, so a stalled receiver holds one result while the
//   next instruction executes, and blocks only on the result after that.
//   Reset: the stack depth goes to zero and a clearing pass zeros the locals
//   memory, one entry a cycle; s_axis_tready stays low during the pass. The
//   stack memory is not cleared: only written entries are ever read. Faults
//   leave the state unchanged and report a status.
module stack_bytecode_executor_core #(
  parameter int unsigned StackDepth = sbe_pkg::StackDepthDef,
  parameter int unsigned LocalCount = sbe_pkg::LocalCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // action[7:0], first_byte[15:8], second_byte[23:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // pc_step[15:0], print_valid[16], print_value[48:17], finish[50:49],
  // return_value[82:51], status[85:83], zero pad [87:86]
  output logic [87:0] m_axis_tdata
);
  localparam int unsigned SAw = $clog2(StackDepth);
  localparam int unsigned LAw = $clog2(LocalCount);
  localparam int unsigned SDw = $clog2(StackDepth + 1);
  localparam int unsigned LCw = $clog2(LocalCount + 1);

  sbe_pkg::state_e state_q, state_d;
  logic [7:0] op_q, b1_q, b2_q;
  logic [SDw-1:0] depth_q;
  logic [LCw-1:0] clr_q;

  // Result register and its flag.
  logic        out_vld_q;
  logic [87:0] out_q;

  // Memories.
  logic           st_we, lv_we;
  logic [SAw-1:0] st_wa, st_ra, lv_wa, lv_ra;
  logic [31:0]    st_wd, lv_wd, st_rd, lv_rd;
  logic [31:0]    top_q;   // top of stack copy, spares a second stack read port
  logic           rld_q, rld_d;  // top copy must be reloaded from memory

  sbe_ram #(.Width(32), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(st_we), .waddr_i(st_wa), .wdata_i(st_wd), .raddr_i(st_ra), .rdata_o(st_rd));
  sbe_ram #(.Width(32), .Depth(LocalCount)) u_locals (
    .clk_i, .we_i(lv_we), .waddr_i(lv_wa), .wdata_i(lv_wd), .raddr_i(lv_ra), .rdata_o(lv_rd));

  // Divider.
  logic [5:0]  dcnt_q;
  logic [31:0] dquo_q, drem_q, ddiv_q;
  logic        dnq_q, dnr_q;

  // Decode of the latched opcode.
  logic       is_const, is_lload, is_lstore, is_alu, is_if, is_cmp;
  logic [7:0] idx;
  logic [1:0] pops, pushes;
  logic       ok_op;
  always_comb begin
    is_const  = op_q >= sbe_pkg::OpIconstM1 && op_q <= sbe_pkg::OpIconst5;
    is_lload  = op_q == sbe_pkg::OpIload || op_q == sbe_pkg::OpAload ||
                (op_q >= sbe_pkg::OpIload0 && op_q <= sbe_pkg::OpIload3) ||
                (op_q >= sbe_pkg::OpAload0 && op_q <= sbe_pkg::OpAload3);
    is_lstore = op_q == sbe_pkg::OpIstore || op_q == sbe_pkg::OpAstore ||
                (op_q >= sbe_pkg::OpIstore0 && op_q <= sbe_pkg::OpIstore3) ||
                (op_q >= sbe_pkg::OpAstore0 && op_q <= sbe_pkg::OpAstore3);
    is_alu    = op_q == sbe_pkg::OpIadd || op_q == sbe_pkg::OpIsub ||
                op_q == sbe_pkg::OpImul || op_q == sbe_pkg::OpIdiv ||
                op_q == sbe_pkg::OpIrem || op_q == sbe_pkg::OpIshl ||
                op_q == sbe_pkg::OpIshr || op_q == sbe_pkg::OpIushr ||
                op_q == sbe_pkg::OpIand || op_q == sbe_pkg::OpIor ||
                op_q == sbe_pkg::OpIxor;
    is_if     = op_q >= sbe_pkg::OpIfeq && op_q <= sbe_pkg::OpIfle;
    is_cmp    = op_q >= sbe_pkg::OpCmpeq && op_q <= sbe_pkg::OpCmple;
    if (op_q == sbe_pkg::OpIload || op_q == sbe_pkg::OpAload ||
        op_q == sbe_pkg::OpIstore || op_q == sbe_pkg::OpAstore ||
        op_q == sbe_pkg::OpIinc) begin
      idx = b1_q;
    end else if (op_q >= sbe_pkg::OpAstore0) idx = op_q - sbe_pkg::OpAstore0;
    else if (op_q >= sbe_pkg::OpIstore0) idx = op_q - sbe_pkg::OpIstore0;
    else if (op_q >= sbe_pkg::OpAload0) idx = op_q - sbe_pkg::OpAload0;
    else idx = op_q - sbe_pkg::OpIload0;
    ok_op = 1'b1;
    pops = 2'd0;
    pushes = 2'd0;
    if (is_const || op_q == sbe_pkg::OpBipush || op_q == sbe_pkg::OpSipush || is_lload)
      pushes = 2'd1;
    else if (is_lstore || is_if || op_q == sbe_pkg::OpIret || op_q == sbe_pkg::OpAret ||
             op_q == sbe_pkg::OpInvokevirt) pops = 2'd1;
    else if (op_q == sbe_pkg::OpDup) begin
      pops = 2'd1; pushes = 2'd2;
    end else if (is_alu) begin
      pops = 2'd2; pushes = 2'd1;
    end else if (op_q == sbe_pkg::OpIneg) begin
      pops = 2'd1; pushes = 2'd1;
    end else if (is_cmp) pops = 2'd2;
    else if (!(op_q == sbe_pkg::OpNop || op_q == sbe_pkg::OpIinc ||
               op_q == sbe_pkg::OpGoto || op_q == sbe_pkg::OpRet ||
               op_q == sbe_pkg::OpGetstatic)) ok_op = 1'b0;
  end

  logic stack_bad, local_bad;
  logic [SDw:0] dep_ext;
  always_comb begin
    dep_ext   = {1'b0, depth_q};
    stack_bad = (dep_ext < {{(SDw-1){1'b0}}, pops}) ||
                (dep_ext - (SDw+1)'(pops) + (SDw+1)'(pushes) > (SDw+1)'(StackDepth));
    local_bad = (is_lload || is_lstore || op_q == sbe_pkg::OpIinc) &&
                ({24'd0, idx} >= 32'(LocalCount));
  end

  // Operands: a is next-to-top (read from memory), b is top.
  logic [31:0] a_v, b_v, alu_r;
  logic [4:0]  sh;
  logic        taken, cmp_eq, cmp_lt;
  logic [15:0] offs;
  assign a_v  = st_rd;
  assign b_v  = top_q;
  assign sh   = b_v[4:0];
  assign offs = {b1_q, b2_q};
  always_comb begin
    case (op_q)
      sbe_pkg::OpIadd:  alu_r = a_v + b_v;
      sbe_pkg::OpIsub:  alu_r = a_v - b_v;
      sbe_pkg::OpImul:  alu_r = a_v * b_v;
      sbe_pkg::OpIshl:  alu_r = a_v << sh;
      sbe_pkg::OpIshr:  alu_r = 32'($signed(a_v) >>> sh);
      sbe_pkg::OpIushr: alu_r = a_v >> sh;
      sbe_pkg::OpIand:  alu_r = a_v & b_v;
      sbe_pkg::OpIor:   alu_r = a_v | b_v;
      default:          alu_r = a_v ^ b_v;
    endcase
    if (is_cmp) begin
      cmp_eq = a_v == b_v;
      cmp_lt = $signed(a_v) < $signed(b_v);
    end else begin
      cmp_eq = b_v == 32'd0;
      cmp_lt = b_v[31];
    end
    case (is_cmp ? op_q - 8'd6 : op_q)
      sbe_pkg::OpIfeq: taken = cmp_eq;
      sbe_pkg::OpIfne: taken = !cmp_eq;
      sbe_pkg::OpIflt: taken = cmp_lt;
      sbe_pkg::OpIfge: taken = !cmp_lt;
      sbe_pkg::OpIfgt: taken = !cmp_lt && !cmp_eq;
      default:         taken = cmp_lt || cmp_eq;
    endcase
  end

  // Divider step on magnitudes.
  logic [32:0] dtrial;
  assign dtrial = {drem_q, dquo_q[31]} - {1'b0, ddiv_q};

  logic [87:0] res;
  logic        res_go;
  logic [SDw-1:0] depth_d;
  logic [31:0] top_d;
  logic [SAw-1:0] top_idx, nxt_idx;
  assign top_idx = SAw'(depth_q - 1'b1);
  assign nxt_idx = SAw'(depth_q - 2'd2);

  function automatic logic [87:0] pack(logic [15:0] pc, logic pv, logic [31:0] pval,
                                       logic [1:0] fin, logic [31:0] rv, logic [2:0] st);
    return {2'b00, st, rv, fin, pval, pv, pc};
  endfunction

  always_comb begin
    state_d = state_q;
    depth_d = depth_q;
    top_d   = top_q;
    rld_d   = rld_q;
    res     = '0;
    res_go  = 1'b0;
    st_we = 1'b0; st_wa = depth_q[SAw-1:0]; st_wd = '0; st_ra = nxt_idx;
    lv_we = 1'b0; lv_wa = idx[LAw-1:0]; lv_wd = '0; lv_ra = idx[LAw-1:0];
    unique case (state_q)
      sbe_pkg::S_CLEAR: begin
        lv_we = 1'b1;
        lv_wa = clr_q[LAw-1:0];
        if (clr_q == LCw'(LocalCount - 1)) state_d = sbe_pkg::S_IDLE;
      end
      sbe_pkg::S_IDLE: begin
        // Pick up the new top read during the last result cycle.
        if (rld_q) begin
          top_d = st_rd;
          rld_d = 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) state_d = sbe_pkg::S_READ;
      end
      sbe_pkg::S_READ: state_d = sbe_pkg::S_EXEC;  // memories present data next cycle
      sbe_pkg::S_EXEC: begin
        if (!ok_op) res = pack('0, 1'b0, '0, '0, '0, sbe_pkg::StUnsup);
        else if (op_q != sbe_pkg::OpIinc && stack_bad)
          res = pack('0, 1'b0, '0, '0, '0, sbe_pkg::StStack);
        else if (local_bad) res = pack('0, 1'b0, '0, '0, '0, sbe_pkg::StLocal);
        else if ((op_q == sbe_pkg::OpIdiv || op_q == sbe_pkg::OpIrem) && b_v == 32'd0)
          res = pack('0, 1'b0, '0, '0, '0, sbe_pkg::StDivZ);
        else if (op_q == sbe_pkg::OpIdiv || op_q == sbe_pkg::OpIrem) begin
          state_d = sbe_pkg::S_DIV;
        end else begin
          res = pack(16'd1, 1'b0, '0, sbe_pkg::FinNone, '0, sbe_pkg::StOk);
          if (is_const || op_q == sbe_pkg::OpBipush || op_q == sbe_pkg::OpSipush ||
              is_lload || op_q == sbe_pkg::OpDup) begin
            st_we = 1'b1;
            if (op_q == sbe_pkg::OpDup) begin
              st_wd = b_v;
              st_wa = top_idx;  // rewrite top slot so the old copy lives in memory
            end else if (is_const) st_wd = 32'(signed'(op_q - 8'd3));
            else if (op_q == sbe_pkg::OpBipush) begin
              st_wd = {{24{b1_q[7]}}, b1_q}; res[15:0] = 16'd2;
            end else if (op_q == sbe_pkg::OpSipush) begin
              st_wd = {{16{offs[15]}}, offs}; res[15:0] = 16'd3;
            end else begin
              st_wd = lv_rd;
              if (op_q == sbe_pkg::OpIload || op_q == sbe_pkg::OpAload) res[15:0] = 16'd2;
            end
            if (op_q != sbe_pkg::OpDup) st_wa = depth_q[SAw-1:0];
            top_d = st_wd;
            depth_d = depth_q + 1'b1;
          end else if (is_lstore) begin
            lv_we = 1'b1; lv_wd = b_v;
            if (op_q == sbe_pkg::OpIstore || op_q == sbe_pkg::OpAstore) res[15:0] = 16'd2;
            depth_d = depth_q - 1'b1; top_d = a_v;
          end else if (is_alu) begin
            depth_d = depth_q - 1'b1; top_d = alu_r;
          end else if (op_q == sbe_pkg::OpIneg) begin
            top_d = 32'd0 - b_v;
          end else if (op_q == sbe_pkg::OpIinc) begin
            lv_we = 1'b1; lv_wd = lv_rd + {{24{b2_q[7]}}, b2_q}; res[15:0] = 16'd3;
          end else if (is_if) begin
            res[15:0] = taken ? offs : 16'd3;
            depth_d = depth_q - 1'b1; top_d = a_v;
          end else if (is_cmp) begin
            // The new top sits two below: fetch it from memory in the result cycle.
            res[15:0] = taken ? offs : 16'd3;
            depth_d = depth_q - 2'd2;
            rld_d = 1'b1;
          end else if (op_q == sbe_pkg::OpGoto) res[15:0] = offs;
          else if (op_q == sbe_pkg::OpGetstatic) res[15:0] = 16'd3;
          else if (op_q == sbe_pkg::OpInvokevirt) begin
            res = pack(16'd3, 1'b1, b_v, sbe_pkg::FinNone, '0, sbe_pkg::StOk);
            depth_d = depth_q - 1'b1; top_d = a_v;
          end else if (op_q == sbe_pkg::OpRet) begin
            res = pack('0, 1'b0, '0, sbe_pkg::FinVoid, '0, sbe_pkg::StOk);
            depth_d = '0;
          end else if (op_q == sbe_pkg::OpIret || op_q == sbe_pkg::OpAret) begin
            res = pack('0, 1'b0, '0, sbe_pkg::FinValue, b_v, sbe_pkg::StOk);
            depth_d = '0;
          end
        end
        if (state_d != sbe_pkg::S_DIV) state_d = sbe_pkg::S_OUT;
      end
      sbe_pkg::S_DIV: begin
        if (dcnt_q == 6'd32) begin
          if (op_q == sbe_pkg::OpIdiv) top_d = dnq_q ? 32'd0 - dquo_q : dquo_q;
          else top_d = dnr_q ? 32'd0 - drem_q : drem_q;
          depth_d = depth_q - 1'b1;
          res = pack(16'd1, 1'b0, '0, sbe_pkg::FinNone, '0, sbe_pkg::StOk);
          state_d = sbe_pkg::S_OUT;
        end
      end
      sbe_pkg::S_OUT: begin
        // Commit the top copy into memory (no-op rewrite when unchanged), or read
        // the new top when the copy is stale, and finish.
        st_ra = rld_q ? top_idx : nxt_idx;
        if (!out_vld_q || m_axis_tready) begin
          res_go = 1'b1;
          state_d = sbe_pkg::S_IDLE;
        end
      end
      default: state_d = sbe_pkg::S_IDLE;
    endcase
    // In S_OUT, unless the stack is empty or the copy is stale, the top copy is written into the top slot.
    if (state_q == sbe_pkg::S_OUT && depth_q != '0 && !rld_q) begin
      st_we = 1'b1; st_wa = top_idx; st_wd = top_q;
    end
  end

  logic [87:0] res_q;
  assign s_axis_tready = state_q == sbe_pkg::S_IDLE;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sbe_pkg::S_CLEAR;
      depth_q   <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
      dcnt_q    <= '0;
      rld_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      depth_q <= depth_d;
      rld_q   <= rld_d;
      if (state_q == sbe_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
      if (res_go) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
      if (state_q == sbe_pkg::S_DIV) dcnt_q <= dcnt_q + 1'b1;
      else dcnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      op_q <= s_axis_tdata[7:0];
      b1_q <= s_axis_tdata[15:8];
      b2_q <= s_axis_tdata[23:16];
    end
    top_q <= top_d;
    if (state_q == sbe_pkg::S_EXEC) res_q <= res;
    else if (state_q == sbe_pkg::S_DIV && dcnt_q == 6'd32) res_q <= res;
    if (res_go) out_q <= res_q;
    if (state_q == sbe_pkg::S_EXEC) begin
      dquo_q <= a_v[31] ? 32'd0 - a_v : a_v;
      ddiv_q <= b_v[31] ? 32'd0 - b_v : b_v;
      drem_q <= '0;
      dnq_q  <= a_v[31] ^ b_v[31];
      dnr_q  <= a_v[31];
    end else if (state_q == sbe_pkg::S_DIV && dcnt_q != 6'd32) begin
      if (!dtrial[32]) begin
        drem_q <= dtrial[31:0];
        dquo_q <= {dquo_q[30:0], 1'b1};
      end else begin
        drem_q <= {drem_q[30:0], dquo_q[31]};
        dquo_q <= {dquo_q[30:0], 1'b0};
      end
    end
  end
endmodule

@@ hdl/sbe_checker.sv @@
// Port-level checker for the bytecode executor, bound to the top level.
`timescale 1ns / 1ps
`include "stack_bytecode_executor_core_defines.svh"
module sbe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);
  `SBE_ASSERT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result beat changed while stalled")
  `SBE_ASSERT(a_fault_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[85:83] != 3'd0 |-> m_axis_tdata[82:0] == 83'd0, "faulted result carries data")
  `SBE_ASSERT(a_no_busy_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "second beat accepted while busy")
  `SBE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid, "result valid during reset")
endmodule
bind stack_bytecode_executor_core sbe_checker u_sbe_checker (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata);
